>>> design/plcwa_pkg.sv
package plcwa_pkg;

    localparam int FRAC_BITS = 16;

    localparam int X_W      = 32;
    localparam int AREA_W   = 47;
    localparam int MUL_W    = X_W + 1;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int MAG_W    = PROD_W - 1;
    localparam int FL_W     = PROD_W - FRAC_BITS;
    localparam int SUM_W    = FL_W + 2;
    localparam int TERM_W   = MAG_W - FRAC_BITS - 1;
    localparam int ASUM_W   = ((TERM_W > AREA_W) ? TERM_W : AREA_W) + 1;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 240;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    localparam logic [2:0] REG_BASELINE   = 3'd0;
    localparam logic [2:0] REG_CHANGE_ONE = 3'd1;
    localparam logic [2:0] REG_CHANGE_TWO = 3'd2;
    localparam logic [2:0] REG_SLOPE_ONE  = 3'd3;
    localparam logic [2:0] REG_SLOPE_TWO  = 3'd4;

    localparam logic [3:0] STEP_LAST = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    function automatic logic signed [X_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [X_W-1:0] r;
        if ((&v[SUM_W-1:X_W-1]) || !(|v[SUM_W-1:X_W-1])) begin
            r = v[X_W-1:0];
        end else if (v[SUM_W-1]) begin
            r = {1'b1, {(X_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(X_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic [MAG_W-1:0] mag(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-1:0] t;
        t = v[PROD_W-1] ? -v : v;
        return t[MAG_W-1:0];
    endfunction

endpackage

>>> design/piecewise_linear_curve_with_area_unit.sv
// Three-segment piecewise linear curve with running trapezoid area. Grid points
// arrive one request at a time on the slave stream (grid_x in tdata, tlast marks
// the final point); every point yields one result with the model value, and the
// final point also carries area, final x/value, peak and both intercepts, after
// which the curve state clears. Point values are signed Q16.16, the area
// unsigned Q31.16; all saturate. One 33x33 multiplier forms eight products in
// turn (three intercept products, both segment products, the two peak-compare
// products and the trapezoid product), each registered for the next step; a done
// state hands the result to the output register once free. The user must write
// registers over APB only while no point is in flight; the block does not check.
module piecewise_linear_curve_with_area_unit import plcwa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,   // [31:0] grid_x
    input  logic                i_s_tlast,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // [31:0] model_value, [78:32] area, [110:79] final_x, [142:111] final_value,
    // [174:143] peak_value, [206:175] intercept_one, [238:207] intercept_two
    output logic [M_DATA_W-1:0] o_m_tdata,
    output logic                o_m_tlast,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    localparam logic [AREA_W-1:0] AREA_MAX = '1;

    t_state r_state, n_state;
    logic [3:0] r_step, n_step;

    logic signed [X_W-1:0] r_base, r_x0, r_x1, r_b0, r_b1;

    logic signed [X_W-1:0]   r_x;
    logic                    r_last;
    logic signed [MUL_W-1:0] r_dx, r_d10, r_dx1, r_ysum;
    logic                    r_lt0, r_le1;

    logic signed [X_W-1:0]   r_px, r_pv;
    logic                    r_have;
    logic [AREA_W-1:0]       r_area;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [FL_W-1:0]   r_pb;
    logic signed [X_W-1:0]    r_y1, r_y2, r_ypk3, r_ymid, r_yfin, r_y, r_peak;
    logic [MAG_W-1:0]         r_rise;

    logic                  r_ovalid, r_olast;
    logic signed [X_W-1:0] r_o_model, r_o_fx, r_o_fv, r_o_peak, r_o_y1, r_o_y2;
    logic [AREA_W-1:0]     r_o_area;

    logic                    w_s_acc, w_cfg_wr, w_out_free, w_load;
    logic [2:0]              w_idx;
    logic signed [MUL_W-1:0] w_mul_a, w_mul_b;
    logic signed [FL_W-1:0]  w_fl;
    logic [MAG_W-1:0]        w_mag;
    logic signed [X_W-1:0]   w_yhi, w_peak;
    logic [TERM_W-1:0]       w_term;
    logic [ASUM_W-1:0]       w_asum;
    logic signed [X_W-1:0]   w_gx;

    assign pready     = 1'b1;
    assign w_idx      = paddr[PADDR_W-1:2];
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_ovalid || i_m_tready;
    assign w_gx       = $signed(i_s_tdata[X_W-1:0]);

    always_comb begin
        case (w_idx)
            REG_BASELINE:   prdata = r_base;
            REG_CHANGE_ONE: prdata = r_x0;
            REG_CHANGE_TWO: prdata = r_x1;
            REG_SLOPE_ONE:  prdata = r_b0;
            REG_SLOPE_TWO:  prdata = r_b1;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_x0   <= '0;
            r_x1   <= '0;
            r_b0   <= '0;
            r_b1   <= '0;
        end else if (w_cfg_wr) begin
            case (w_idx)
                REG_BASELINE:   r_base <= pwdata;
                REG_CHANGE_ONE: r_x0   <= pwdata;
                REG_CHANGE_TWO: r_x1   <= pwdata;
                REG_SLOPE_ONE:  r_b0   <= pwdata;
                REG_SLOPE_TWO:  r_b1   <= pwdata;
                default:        ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        w_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                n_step = '0;
                if (w_s_acc) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_step == STEP_LAST) begin
                    n_state = ST_DONE;
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // shared multiplier operand select
    always_comb begin
        case (r_step)
            4'd0:    begin w_mul_a = MUL_W'(r_b0); w_mul_b = MUL_W'(r_x0); end
            4'd1:    begin w_mul_a = MUL_W'(r_b0); w_mul_b = MUL_W'(r_x1); end
            4'd2:    begin w_mul_a = MUL_W'(r_b1); w_mul_b = MUL_W'(r_x1); end
            4'd3:    begin w_mul_a = MUL_W'(r_b0); w_mul_b = MUL_W'(r_x);  end
            4'd4:    begin w_mul_a = MUL_W'(r_b1); w_mul_b = MUL_W'(r_x);  end
            4'd5:    begin w_mul_a = MUL_W'(r_b0); w_mul_b = r_d10;        end
            4'd6:    begin w_mul_a = MUL_W'(r_b1); w_mul_b = r_dx1;        end
            4'd7:    begin w_mul_a = r_dx;         w_mul_b = r_ysum;       end
            default: begin w_mul_a = '0;           w_mul_b = '0;           end
        endcase
    end

    assign w_fl   = $signed(r_prod[FRAC_BITS +: FL_W]);
    assign w_mag  = mag(r_prod);
    assign w_yhi  = sat32(SUM_W'(w_fl) + SUM_W'(r_y2));
    assign w_term = w_mag[MAG_W-1:FRAC_BITS+1];
    assign w_asum = ASUM_W'(r_area) + ASUM_W'(w_term);

    // peak by slope signs, else by comparing r_rise with w_mag; w_mag holds |b1*(x-x1)| at step 7
    always_comb begin
        if (!r_b0[X_W-1] && !r_b1[X_W-1]) begin
            w_peak = r_yfin;
        end else if (r_b0[X_W-1] && r_b1[X_W-1]) begin
            w_peak = r_base;
        end else if (!r_b0[X_W-1] && (r_b0 != '0) && r_b1[X_W-1]) begin
            w_peak = r_ypk3;
        end else begin
            w_peak = (r_rise >= w_mag) ? r_base : r_yfin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_x    <= w_gx;
            r_last <= i_s_tlast;
            r_dx   <= MUL_W'(w_gx) - MUL_W'(r_px);
            r_d10  <= MUL_W'(r_x1) - MUL_W'(r_x0);
            r_dx1  <= MUL_W'(w_gx) - MUL_W'(r_x1);
            r_lt0  <= (w_gx < r_x0);
            r_le1  <= (w_gx <= r_x1);
        end
        if (r_state == ST_RUN) begin
            r_prod <= w_mul_a * w_mul_b;
            case (r_step)
                4'd1: r_y1 <= sat32(SUM_W'(r_base) - SUM_W'(w_fl));
                4'd2: r_pb <= w_fl;
                4'd3: begin
                    r_y2   <= sat32(SUM_W'(r_pb) + SUM_W'(r_y1) - SUM_W'(w_fl));
                    r_ypk3 <= sat32(SUM_W'(r_pb) + SUM_W'(r_y1));
                end
                4'd4: r_ymid <= sat32(SUM_W'(w_fl) + SUM_W'(r_y1));
                4'd5: begin
                    r_yfin <= w_yhi;
                    r_y    <= r_lt0 ? r_base : (r_le1 ? r_ymid : w_yhi);
                end
                4'd6: begin
                    r_rise <= w_mag;
                    r_ysum <= MUL_W'(r_pv) + MUL_W'(r_y);
                end
                4'd7: r_peak <= w_peak;
                default: ;
            endcase
        end
    end

    // curve state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px   <= '0;
            r_pv   <= '0;
            r_have <= 1'b0;
            r_area <= '0;
        end else if ((r_state == ST_RUN) && (r_step == STEP_LAST) && r_have) begin
            r_area <= (w_asum > ASUM_W'(AREA_MAX)) ? AREA_MAX : w_asum[AREA_W-1:0];
        end else if (w_load) begin
            if (r_last) begin
                r_px   <= '0;
                r_pv   <= '0;
                r_have <= 1'b0;
                r_area <= '0;
            end else begin
                r_px   <= r_x;
                r_pv   <= r_y;
                r_have <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_olast   <= r_last;
            r_o_model <= r_y;
            r_o_area  <= r_last ? r_area : '0;
            r_o_fx    <= r_last ? r_x    : '0;
            r_o_fv    <= r_last ? r_yfin : '0;
            r_o_peak  <= r_last ? r_peak : '0;
            r_o_y1    <= r_last ? r_y1   : '0;
            r_o_y2    <= r_last ? r_y2   : '0;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tlast  = r_olast;
    assign o_m_tdata  = {1'b0, r_o_y2, r_o_y1, r_o_peak, r_o_fv, r_o_fx, r_o_area, r_o_model};

endmodule

>>> design/plcwa_checker.sv
module plcwa_checker import plcwa_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_tvalid,
    input logic                o_s_tready,
    input logic                o_m_tvalid,
    input logic                i_m_tready,
    input logic [M_DATA_W-1:0] o_m_tdata,
    input logic                o_m_tlast
);

    // a point stays in flight after it is accepted
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request accepted while previous point in flight");

    // summary fields only on the last point
    a_summary_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> (o_m_tdata[M_DATA_W-1:X_W] == '0))
        else $error("summary fields nonzero on inner point");

    // a result drained while the input side is idle leaves the output empty
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && o_s_tready |=> !o_m_tvalid)
        else $error("result request followed too closely");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled result request changed");

endmodule

bind piecewise_linear_curve_with_area_unit plcwa_checker u_plcwa_checker (.*);
